[hw/rtl/ssrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrc_pkg
// Shared types and codes for the supply set-point / read-back controller.
// ----------------------------------------------------------------------------
package ssrc_pkg;

  // Default host packet length in bytes
  localparam int unsigned PacketBytesDef = 5;

  // Result queue depth
  localparam int unsigned FifoDepth = 4;

  // Input event codes (carried on s_axis_tuser)
  localparam logic [2:0] OP_SEL_FALL = 3'd0;
  localparam logic [2:0] OP_SER_BYTE = 3'd1;
  localparam logic [2:0] OP_SEL_RISE = 3'd2;
  localparam logic [2:0] OP_BUS_DONE = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;

  // Result kind codes (carried on m_axis_tuser)
  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_DAC     = 2'd1;
  localparam logic [1:0] KIND_SEL_WR  = 2'd2;
  localparam logic [1:0] KIND_RD_REQ  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_WR_CODE  = 3'd0;
  localparam logic [2:0] REG_V_SEL    = 3'd1;
  localparam logic [2:0] REG_C_SEL    = 3'd2;
  localparam logic [2:0] REG_HI_MASK  = 3'd3;
  localparam logic [2:0] REG_DLY      = 3'd4;

  // Converter command word bits
  localparam logic [15:0] DAC_CH_B_SEL = 16'h8000;
  localparam logic [15:0] DAC_ACTIVE   = 16'h2000;
  localparam logic [15:0] DAC_ENABLE   = 16'h1000;

  // Mask on the set-point high byte
  localparam logic [7:0] SETPT_HI_MASK = 8'h0F;

  // Delay counter saturation value
  localparam logic [7:0] DLY_MAX = 8'hFF;

  // Configuration registers
  typedef struct packed {
    logic [7:0] wr_code;
    logic [7:0] v_sel;
    logic [7:0] c_sel;
    logic [7:0] hi_mask;
    logic [7:0] dly_ticks;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] serial_byte;
    logic       bus_error;
    logic [7:0] read_high_byte;
    logic [7:0] read_low_byte;
  } item_t;

  // One result item
  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] dac_word;
    logic        dac_latch;
    logic        last;
  } res_t;

  // Results pushed into the queue in one cycle (0, 1 or 2)
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } res_push_t;

endpackage

[hw/rtl/ssrc_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrc_core
// Controller state and result generation; one input item handled per fire.
// ----------------------------------------------------------------------------
module ssrc_core import ssrc_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PacketBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  item_t     item_i,
  input  cfg_t      cfg_i,
  output res_push_t push_o
);

  localparam int unsigned CntW = $clog2(PACKET_BYTES + 1);
  localparam int unsigned IdxW = $clog2(PACKET_BYTES);
  localparam logic [CntW-1:0] PktFull = CntW'(PACKET_BYTES);
  localparam logic [CntW-1:0] SnapCnt = CntW'(4);

  // Converter sequence codes
  localparam logic [2:0] SEQ_WR_V   = 3'd0;
  localparam logic [2:0] SEQ_WT_V   = 3'd1;
  localparam logic [2:0] SEQ_RD_V   = 3'd2;
  localparam logic [2:0] SEQ_WR_C   = 3'd3;
  localparam logic [2:0] SEQ_WT_C   = 3'd4;
  localparam logic [2:0] SEQ_RD_C   = 3'd5;
  localparam logic [2:0] SEQ_UNINIT = 3'd6;

  logic [7:0]      rx_q [PACKET_BYTES];
  logic            rx_we;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      snap_q [4];
  logic            snap_we;
  logic [11:0]     vsp_q, vsp_d, csp_q, csp_d;
  logic [15:0]     vrd_q, vrd_d, crd_q, crd_d;
  logic [2:0]      seq_q, seq_d;
  logic [7:0]      dly_q, dly_d, dly_inc;
  logic [15:0]     rd_val;
  logic            pkt_ok;

  assign rd_val  = {item_i.read_high_byte & cfg_i.hi_mask, item_i.read_low_byte};
  assign dly_inc = (dly_q == DLY_MAX) ? dly_q : dly_q + 8'd1;
  assign pkt_ok  = (cnt_q == PktFull);

  // Event decode and next state
  always_comb begin
    cnt_d   = cnt_q;
    vsp_d   = vsp_q;
    csp_d   = csp_q;
    vrd_d   = vrd_q;
    crd_d   = crd_q;
    seq_d   = seq_q;
    dly_d   = dly_q;
    rx_we   = 1'b0;
    snap_we = 1'b0;
    push_o  = '0;
    if (fire_i) begin
      unique case (item_i.op)
        OP_SEL_FALL: begin
          cnt_d   = '0;
          snap_we = 1'b1;
        end
        OP_SER_BYTE: begin
          if (cnt_q < PktFull) begin
            rx_we                 = 1'b1;
            cnt_d                 = cnt_q + CntW'(1);
            push_o.num            = 2'd1;
            push_o.first.out_kind = KIND_REPLY;
            push_o.first.out_byte = (cnt_q < SnapCnt) ? snap_q[cnt_q[1:0]] : 8'h00;
            push_o.first.last     = 1'b1;
          end
        end
        OP_SEL_RISE: begin
          if (rx_q[0] == cfg_i.wr_code) begin
            if (pkt_ok) begin
              vsp_d = {rx_q[1][3:0] & SETPT_HI_MASK[3:0], rx_q[2]};
              csp_d = {rx_q[3][3:0] & SETPT_HI_MASK[3:0], rx_q[4]};
            end
            // Enable bits are crossed between the two channels
            push_o.num             = 2'd2;
            push_o.first.out_kind  = KIND_DAC;
            push_o.first.dac_word  = DAC_CH_B_SEL | DAC_ACTIVE |
                                     ((csp_d != '0) ? DAC_ENABLE : '0) |
                                     {4'h0, vsp_d};
            push_o.second.out_kind  = KIND_DAC;
            push_o.second.dac_word  = DAC_ACTIVE |
                                      ((vsp_d != '0) ? DAC_ENABLE : '0) |
                                      {4'h0, csp_d};
            push_o.second.dac_latch = 1'b1;
            push_o.second.last      = 1'b1;
          end
        end
        OP_BUS_DONE: begin
          priority if (seq_q == SEQ_WR_V || seq_q == SEQ_WR_C) begin
            if (item_i.bus_error) begin
              seq_d = SEQ_UNINIT;
            end else begin
              dly_d = '0;
              seq_d = (seq_q == SEQ_WR_V) ? SEQ_WT_V : SEQ_WT_C;
            end
          end else if (seq_q == SEQ_RD_V || seq_q == SEQ_RD_C) begin
            if (item_i.bus_error) begin
              seq_d = SEQ_UNINIT;
            end else begin
              push_o.num            = 2'd1;
              push_o.first.out_kind = KIND_SEL_WR;
              push_o.first.last     = 1'b1;
              if (seq_q == SEQ_RD_V) begin
                vrd_d                 = rd_val;
                seq_d                 = SEQ_WR_C;
                push_o.first.out_byte = cfg_i.c_sel;
              end else begin
                crd_d                 = rd_val;
                seq_d                 = SEQ_WR_V;
                push_o.first.out_byte = cfg_i.v_sel;
              end
            end
          end else begin
          end
        end
        OP_TICK: begin
          priority if (seq_q == SEQ_UNINIT) begin
            seq_d                 = SEQ_WR_V;
            push_o.num            = 2'd1;
            push_o.first.out_kind = KIND_SEL_WR;
            push_o.first.out_byte = cfg_i.v_sel;
            push_o.first.last     = 1'b1;
          end else if (seq_q == SEQ_WT_V || seq_q == SEQ_WT_C) begin
            dly_d = dly_inc;
            if (dly_inc >= cfg_i.dly_ticks) begin
              seq_d                 = (seq_q == SEQ_WT_V) ? SEQ_RD_V : SEQ_RD_C;
              push_o.num            = 2'd1;
              push_o.first.out_kind = KIND_RD_REQ;
              push_o.first.last     = 1'b1;
            end
          end else begin
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Packet and snapshot storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PACKET_BYTES; k++) rx_q[k] <= '0;
      for (int k = 0; k < 4; k++) snap_q[k] <= '0;
    end else begin
      if (rx_we) rx_q[cnt_q[IdxW-1:0]] <= item_i.serial_byte;
      if (snap_we) begin
        snap_q[0] <= vrd_q[15:8];
        snap_q[1] <= vrd_q[7:0];
        snap_q[2] <= crd_q[15:8];
        snap_q[3] <= crd_q[7:0];
      end
    end
  end

  // Control and value registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vsp_q <= '0;
      csp_q <= '0;
      vrd_q <= '0;
      crd_q <= '0;
      seq_q <= SEQ_UNINIT;
      dly_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      vsp_q <= vsp_d;
      csp_q <= csp_d;
      vrd_q <= vrd_d;
      crd_q <= crd_d;
      seq_q <= seq_d;
      dly_q <= dly_d;
    end
  end

endmodule

[hw/rtl/ssrc_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrc_out_fifo
// Four-entry result queue; takes up to two results a cycle, sends one while the output side is ready.
// ----------------------------------------------------------------------------
module ssrc_out_fifo import ssrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      space_o,
  output logic      valid_o,
  input  logic      ready_i,
  output res_t      head_o
);

  res_t       mem_q [FifoDepth];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 3'd0);
  assign head_o  = mem_q[rd_ptr_q];
  // Room for two more regardless of the output side
  assign space_o = (cnt_q <= 3'd2);

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_ptr_q] <= push_i.first;
    if (push_i.num == 2'd2) mem_q[wr_ptr_q + 2'd1] <= push_i.second;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.num;
      if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, push_i.num} - {2'b00, pop};
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("result queue count overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> (cnt_q <= 3'd2)) else $error("push without room");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.num == 2'd0) |=> (cnt_q == $past(cnt_q) - 3'd1))
    else $error("count did not drop on pop");
`endif

endmodule

[hw/rtl/supply_setpoint_readback_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_setpoint_readback_controller_top
// Host packet handling, set-point converter words and read-back sequencing.
// ----------------------------------------------------------------------------
// One input item is accepted every cycle while the result queue has room for
// two; an item goes from the input register through the control logic into a
// four-entry result queue, and its first result is offered once it has been
// written into the queue. A select rise with the set-point code yields two
// results, which leave one per cycle while the result side is ready, so a
// steady run of those is held back by the queue; every other event yields
// at most one result.
module supply_setpoint_readback_controller_top import ssrc_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PacketBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] serial_byte, [8] bus_error, [16:9] read_high_byte,
  // [24:17] read_low_byte, [31:25] zero
  input  logic [31:0] s_axis_tdata,
  // [2:0] op
  input  logic [2:0]  s_axis_tuser,
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [23:8] dac_word, [24] dac_latch, [31:25] zero
  output logic [31:0] m_axis_tdata,
  // [1:0] out_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i
);

  logic      in_valid_q;
  item_t     in_item_q;
  logic      fire;
  logic      space;
  cfg_t      cfg_q;
  res_push_t push;
  res_t      head;

  // Input register
  assign fire          = in_valid_q && space;
  assign s_axis_tready = !in_valid_q || space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.op             <= s_axis_tuser;
      in_item_q.serial_byte    <= s_axis_tdata[7:0];
      in_item_q.bus_error      <= s_axis_tdata[8];
      in_item_q.read_high_byte <= s_axis_tdata[16:9];
      in_item_q.read_low_byte  <= s_axis_tdata[24:17];
    end
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wr_code   <= 8'd1;
      cfg_q.v_sel     <= 8'd0;
      cfg_q.c_sel     <= 8'd0;
      cfg_q.hi_mask   <= 8'd15;
      cfg_q.dly_ticks <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_WR_CODE: cfg_q.wr_code   <= cfg_data_i;
        REG_V_SEL:   cfg_q.v_sel     <= cfg_data_i;
        REG_C_SEL:   cfg_q.c_sel     <= cfg_data_i;
        REG_HI_MASK: cfg_q.hi_mask   <= cfg_data_i;
        REG_DLY:     cfg_q.dly_ticks <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ssrc_core #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .push_o (push)
  );

  ssrc_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  // Result packing
  assign m_axis_tdata = {7'd0, head.dac_latch, head.dac_word, head.out_byte};
  assign m_axis_tuser = head.out_kind;
  assign m_axis_tlast = head.last;

endmodule

[sim/tb_supply_setpoint_readback_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_supply_setpoint_readback_controller_top
// Self-checking bench for the set-point / read-back controller. Host
// transfers (select fall, serial bytes, select rise) and converter read-back
// events (ticks, bus completions) are driven on the input stream. A shadow
// controller inside the bench predicts every result item, and the monitor
// compares each one field by field. Register settings are swept between
// phases, both stream sides are throttled at random, and the result side is held off once.
// ----------------------------------------------------------------------------
module tb_supply_setpoint_readback_controller_top;
  import ssrc_pkg::*;

  localparam int unsigned PKT_LEN      = PacketBytesDef;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned QUIET_CYCLES = 16;
  localparam int unsigned STALL_CYCLES = 300;

  // Read-back sequencer phases of the shadow controller
  typedef enum logic [2:0] {
    SQ_WR_V, SQ_WT_V, SQ_RD_V, SQ_WR_C, SQ_WT_C, SQ_RD_C, SQ_IDLE
  } conv_phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i;
  logic [7:0]  cfg_data_i;

  // Shadow controller state
  cfg_t        shadow_cfg;
  logic [7:0]  host_bytes [PKT_LEN];
  int unsigned host_count;
  logic [7:0]  reply_bytes [4];
  logic [11:0] v_setpoint;
  logic [11:0] c_setpoint;
  logic [15:0] v_reading;
  logic [15:0] c_reading;
  conv_phase_e conv_phase;
  logic [7:0]  settle_ticks;

  res_t        pending_results [$];
  res_t        head_result;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          stall_request;

  supply_setpoint_readback_controller_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_supply_setpoint_readback_controller_top: done, errors");
      $finish;
    end
  end

  // Result side: random throttling plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor: compare each accepted item with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d tdata %h last %0b",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (head_result.out_kind !== m_axis_tuser) begin
          $error("out_kind: expected %0d, got %0d", head_result.out_kind, m_axis_tuser);
          error_count++;
        end
        if (head_result.out_byte !== m_axis_tdata[7:0]) begin
          $error("out_byte: expected %h, got %h", head_result.out_byte, m_axis_tdata[7:0]);
          error_count++;
        end
        if (head_result.dac_word !== m_axis_tdata[23:8]) begin
          $error("dac_word: expected %h, got %h", head_result.dac_word, m_axis_tdata[23:8]);
          error_count++;
        end
        if (head_result.dac_latch !== m_axis_tdata[24]) begin
          $error("dac_latch: expected %0b, got %0b", head_result.dac_latch, m_axis_tdata[24]);
          error_count++;
        end
        if (head_result.last !== m_axis_tlast) begin
          $error("last: expected %0b, got %0b", head_result.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  function automatic res_t make_result(logic [1:0] kind, logic [7:0] data_byte,
                                       logic [15:0] word, logic latch, logic fin);
    res_t r;
    r.out_kind  = kind;
    r.out_byte  = data_byte;
    r.dac_word  = word;
    r.dac_latch = latch;
    r.last      = fin;
    return r;
  endfunction

  // Shadow controller: update state and queue the results of one event
  task automatic advance_controller(input item_t ev);
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] value;
    logic [7:0]  reply;
    case (ev.op)
      OP_SEL_FALL: begin
        host_count     = 0;
        reply_bytes[0] = v_reading[15:8];
        reply_bytes[1] = v_reading[7:0];
        reply_bytes[2] = c_reading[15:8];
        reply_bytes[3] = c_reading[7:0];
      end
      OP_SER_BYTE: begin
        // bytes past the packet length are dropped
        if (host_count < PKT_LEN) begin
          host_bytes[host_count] = ev.serial_byte;
          reply = (host_count < 4) ? reply_bytes[host_count] : 8'h00;
          host_count++;
          pending_results.push_back(make_result(KIND_REPLY, reply, 16'h0, 1'b0, 1'b1));
        end
      end
      OP_SEL_RISE: begin
        if (host_bytes[0] == shadow_cfg.wr_code) begin
          if (host_count == PKT_LEN) begin
            v_setpoint = {host_bytes[1][3:0] & SETPT_HI_MASK[3:0], host_bytes[2]};
            c_setpoint = {host_bytes[3][3:0] & SETPT_HI_MASK[3:0], host_bytes[4]};
          end
          // enable bits are crossed between the channels
          word_a = DAC_CH_B_SEL | DAC_ACTIVE | ((c_setpoint != 0) ? DAC_ENABLE : 16'h0)
                   | {4'h0, v_setpoint};
          word_b = DAC_ACTIVE | ((v_setpoint != 0) ? DAC_ENABLE : 16'h0)
                   | {4'h0, c_setpoint};
          pending_results.push_back(make_result(KIND_DAC, 8'h00, word_a, 1'b0, 1'b0));
          pending_results.push_back(make_result(KIND_DAC, 8'h00, word_b, 1'b1, 1'b1));
        end
      end
      OP_BUS_DONE: begin
        case (conv_phase)
          SQ_WR_V, SQ_WR_C: begin
            if (ev.bus_error) begin
              conv_phase = SQ_IDLE;
            end else begin
              settle_ticks = 8'h00;
              conv_phase   = (conv_phase == SQ_WR_V) ? SQ_WT_V : SQ_WT_C;
            end
          end
          SQ_RD_V, SQ_RD_C: begin
            if (ev.bus_error) begin
              conv_phase = SQ_IDLE;
            end else begin
              value = {ev.read_high_byte & shadow_cfg.hi_mask, ev.read_low_byte};
              if (conv_phase == SQ_RD_V) begin
                v_reading  = value;
                conv_phase = SQ_WR_C;
                pending_results.push_back(
                  make_result(KIND_SEL_WR, shadow_cfg.c_sel, 16'h0, 1'b0, 1'b1));
              end else begin
                c_reading  = value;
                conv_phase = SQ_WR_V;
                pending_results.push_back(
                  make_result(KIND_SEL_WR, shadow_cfg.v_sel, 16'h0, 1'b0, 1'b1));
              end
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        case (conv_phase)
          SQ_IDLE: begin
            conv_phase = SQ_WR_V;
            pending_results.push_back(
              make_result(KIND_SEL_WR, shadow_cfg.v_sel, 16'h0, 1'b0, 1'b1));
          end
          SQ_WT_V, SQ_WT_C: begin
            if (settle_ticks != DLY_MAX) settle_ticks++;
            if (settle_ticks >= shadow_cfg.dly_ticks) begin
              conv_phase = (conv_phase == SQ_WT_V) ? SQ_RD_V : SQ_RD_C;
              pending_results.push_back(make_result(KIND_RD_REQ, 8'h00, 16'h0, 1'b0, 1'b1));
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  // Offer one event on the input stream and wait for it to be taken
  task automatic send_event(input logic [2:0] op, input logic [7:0] sbyte,
                            input logic err, input logic [7:0] hi, input logic [7:0] lo);
    item_t ev;
    ev.op             = op;
    ev.serial_byte    = sbyte;
    ev.bus_error      = err;
    ev.read_high_byte = hi;
    ev.read_low_byte  = lo;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    // {pad, read_low_byte, read_high_byte, bus_error, serial_byte}
    s_axis_tdata  <= {7'd0, lo, hi, err, sbyte};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_controller(ev);
    if (op <= OP_TICK) items_sent++;
  endtask

  // Event with all data fields random
  task automatic send_op(input logic [2:0] op);
    send_event(op, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Stop offering and let every predicted result drain out
  task automatic wait_until_quiet();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_WR_CODE: shadow_cfg.wr_code   = val;
      REG_V_SEL:   shadow_cfg.v_sel     = val;
      REG_C_SEL:   shadow_cfg.c_sel     = val;
      REG_HI_MASK: shadow_cfg.hi_mask   = val;
      REG_DLY:     shadow_cfg.dly_ticks = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Host transfer: select fall, n bytes, select rise
  task automatic run_host_transfer(input int unsigned n_bytes, input bit code_first);
    send_op(OP_SEL_FALL);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if (i == 0 && code_first)
        send_event(OP_SER_BYTE, shadow_cfg.wr_code, 1'($urandom), 8'($urandom),
                   8'($urandom));
      else
        send_op(OP_SER_BYTE);
    end
    send_op(OP_SEL_RISE);
  endtask

  // Mostly well-formed packets, some short, long or with a foreign first byte
  task automatic random_host_transfer();
    int unsigned pick;
    int unsigned n_bytes;
    pick = $urandom_range(9);
    if (pick == 7)      n_bytes = $urandom_range(4);
    else if (pick == 8) n_bytes = $urandom_range(PKT_LEN + 3, PKT_LEN + 1);
    else                n_bytes = PKT_LEN;
    run_host_transfer(n_bytes, $urandom_range(99) < 75);
  endtask

  // Usually the next event the read-back sequence is waiting for, errors at err_pct
  task automatic step_converter(input int unsigned err_pct);
    case (conv_phase)
      SQ_WR_V, SQ_WR_C, SQ_RD_V, SQ_RD_C: begin
        if ($urandom_range(99) < 10)
          send_op(OP_TICK);
        else
          send_event(OP_BUS_DONE, 8'($urandom), $urandom_range(99) < err_pct,
                     8'($urandom), 8'($urandom));
      end
      default: send_op(OP_TICK);
    endcase
  endtask

  task automatic random_action();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)      random_host_transfer();
    else if (pick < 90) step_converter(6);
    else                send_op(3'($urandom_range(7)));
  endtask

  // Extremes of every field and each corner of the sequencer
  task automatic test_directed_cases();
    tx_idle_pct = 27;
    rx_idle_pct = 69;
    send_op(OP_BUS_DONE);                                   // ignored before first tick
    send_op(OP_TICK);                                       // voltage selection write
    send_op(OP_TICK);                                       // tick while writing
    send_event(OP_BUS_DONE, 8'h00, 1'b0, 8'h00, 8'h00);     // into wait
    send_event(OP_BUS_DONE, 8'hFF, 1'b1, 8'hFF, 8'hFF);     // ignored in wait
    send_op(OP_TICK);                                       // read request
    send_event(OP_BUS_DONE, 8'h00, 1'b0, 8'hFF, 8'hFF);     // full-scale reading
    send_event(OP_BUS_DONE, 8'hFF, 1'b0, 8'h00, 8'h00);
    send_op(OP_TICK);
    send_event(OP_BUS_DONE, 8'h00, 1'b1, 8'h00, 8'h00);     // read error
    send_op(OP_TICK);
    send_event(OP_BUS_DONE, 8'h00, 1'b1, 8'h00, 8'h00);     // write error
    send_event(3'd5, 8'hFF, 1'b1, 8'hFF, 8'hFF);            // undefined ops
    send_event(3'd7, 8'h00, 1'b0, 8'h00, 8'h00);
    send_op(OP_SEL_RISE);                                   // rise with no bytes
    send_op(OP_SEL_FALL);
    send_event(OP_SER_BYTE, shadow_cfg.wr_code, 1'b0, 8'h00, 8'h00);
    send_event(OP_SER_BYTE, 8'hFF, 1'b0, 8'h00, 8'h00);
    send_event(OP_SER_BYTE, 8'hFF, 1'b0, 8'h00, 8'h00);
    send_event(OP_SER_BYTE, 8'hFF, 1'b0, 8'h00, 8'h00);
    send_event(OP_SER_BYTE, 8'hFF, 1'b0, 8'h00, 8'h00);     // reply past snapshot
    send_event(OP_SER_BYTE, 8'h00, 1'b0, 8'h00, 8'h00);     // packet overflow
    send_op(OP_SEL_RISE);                                   // full-scale set-points
    wait_until_quiet();
  endtask

  task automatic apply_settings(input logic [7:0] code, input logic [7:0] vsel,
                                input logic [7:0] csel, input logic [7:0] mask,
                                input logic [7:0] dly);
    write_register(REG_WR_CODE, code);
    write_register(REG_V_SEL, vsel);
    write_register(REG_C_SEL, csel);
    write_register(REG_HI_MASK, mask);
    write_register(REG_DLY, dly);
  endtask

  task automatic exercise_setting(input int unsigned conv_steps);
    random_host_transfer();
    run_host_transfer(PKT_LEN, 1'b1);
    for (int unsigned i = 0; i < conv_steps; i++) step_converter(0);
    run_host_transfer(PKT_LEN, 1'b1);
    wait_until_quiet();
  endtask

  // Register sweep, extremes first
  task automatic test_register_settings();
    tx_idle_pct = 27;
    rx_idle_pct = 69;
    apply_settings(8'h00, 8'h00, 8'hFF, 8'h00, 8'h00);
    exercise_setting(16);
    // longest settle time: one conversion needs the full count
    apply_settings(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF);
    tx_idle_pct = 69;
    rx_idle_pct = 27;
    exercise_setting(280);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom_range(6, 2)));
    exercise_setting(24);
    // indexes past the register file are ignored
    write_register(3'd5, 8'($urandom));
    write_register(3'd6, 8'($urandom));
    write_register(3'd7, 8'($urandom));
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'h0F,
                   8'($urandom_range(3, 1)));
  endtask

  // Result side held off while host packets keep arriving
  task automatic test_output_hold_off();
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    stall_request = 1'b1;
    for (int i = 0; i < 3; i++) run_host_transfer(PKT_LEN, 1'b1);
    for (int i = 0; i < 8; i++) step_converter(0);
    wait_until_quiet();
  endtask

  // Sender waits for every result before the next burst
  task automatic test_paused_sender();
    tx_idle_pct = 27;
    rx_idle_pct = 69;
    for (int i = 0; i < 3; i++) begin
      random_host_transfer();
      wait_until_quiet();
      for (int j = 0; j < 4; j++) step_converter(10);
      wait_until_quiet();
    end
  endtask

  task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                              input int unsigned n_items);
    int unsigned start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = items_sent;
    while (items_sent - start < n_items) random_action();
  endtask

  task automatic test_random_traffic();
    random_phase(27, 69, 30);
    random_phase(69, 27, 30);
    random_phase(0, 0, 30);
    wait_until_quiet();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    stall_request = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    items_sent    = 0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    // reset values of the shadow controller
    shadow_cfg.wr_code   = 8'd1;
    shadow_cfg.v_sel     = 8'd0;
    shadow_cfg.c_sel     = 8'd0;
    shadow_cfg.hi_mask   = 8'd15;
    shadow_cfg.dly_ticks = 8'd1;
    foreach (host_bytes[i]) host_bytes[i] = 8'h00;
    foreach (reply_bytes[i]) reply_bytes[i] = 8'h00;
    host_count   = 0;
    v_setpoint   = '0;
    c_setpoint   = '0;
    v_reading    = '0;
    c_reading    = '0;
    conv_phase   = SQ_IDLE;
    settle_ticks = 8'h00;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_register_settings();
    test_output_hold_off();
    test_paused_sender();
    test_random_traffic();

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_supply_setpoint_readback_controller_top: done, clean");
    end else begin
      $display("tb_supply_setpoint_readback_controller_top: done, errors");
    end
    $finish;
  end

endmodule
